@@ rtl/srg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srg_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned PER_W   = 32;
  localparam int unsigned BRK_W   = 31;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned OUT_W   = 40;

  localparam logic [PER_W-1:0] START_PERIOD_RST = 32'd362039;
  localparam logic [PER_W-1:0] CRUISE_PERIOD_RST = 32'd16000;
  localparam logic [BRK_W-1:0] FULL_BRAKE_RST = 31'd512;
  localparam logic [PER_W-1:0] ACCEL_RST = 32'd70368744;

  localparam logic [KIND_W-1:0] REQ_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] REQ_MOVE   = 2'd1;
  localparam logic [KIND_W-1:0] REQ_PRESET = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_START_PERIOD  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_CRUISE_PERIOD = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_FULL_BRAKE    = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_ACCEL         = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_CHECK,
    S_DIFF,
    S_ABS,
    S_MSET,
    S_STEP,
    S_RAMP,
    S_FIN
  } ctl_state_t;

  typedef enum logic [3:0] {
    R_IDLE,
    R_PSQ,
    R_SLA,
    R_SHA,
    R_QSUM,
    R_QLP,
    R_QHP,
    R_DSUM,
    R_ADJ,
    R_CLIP,
    R_DONE
  } ramp_state_t;

  typedef struct packed {
    logic             start;
    logic             braking;
    logic [PER_W-1:0] period;
  } ramp_req_t;

  typedef struct packed {
    logic             done;
    logic [PER_W-1:0] period;
  } ramp_rsp_t;

endpackage

`default_nettype wire

@@ rtl/srg_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srg_mul
  import srg_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic [PER_W-1:0]     op_a,
  input  wire logic [PER_W-1:0]     op_b,
  output logic      [2*PER_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= {{PER_W{1'b0}}, op_a} * {{PER_W{1'b0}}, op_b};
  end

endmodule

`default_nettype wire

@@ rtl/srg_ramp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srg_ramp
  import srg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [PER_W-1:0] accel,
  input  wire logic [PER_W-1:0] cruise,
  input  wire ramp_req_t        req,
  output ramp_rsp_t             rsp
);

  ramp_state_t state_r, state_nxt;

  logic [PER_W-1:0]   p_r;
  logic               brk_r;
  logic [PER_W-1:0]   shi_r;
  logic [PER_W-1:0]   hi_r;
  logic [2*PER_W-1:0] q_r;
  logic [2*PER_W-1:0] d_r;
  logic [PER_W-1:0]   raw_r;
  logic [PER_W-1:0]   np_r;

  logic [PER_W-1:0]   op_a;
  logic [PER_W-1:0]   op_b;
  logic [2*PER_W-1:0] prod_r;
  logic [PER_W:0]     sum33;

  srg_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      R_IDLE:  if (req.start) state_nxt = R_PSQ;
      R_PSQ:   state_nxt = R_SLA;
      R_SLA:   state_nxt = R_SHA;
      R_SHA:   state_nxt = R_QSUM;
      R_QSUM:  state_nxt = R_QLP;
      R_QLP:   state_nxt = R_QHP;
      R_QHP:   state_nxt = R_DSUM;
      R_DSUM:  state_nxt = R_ADJ;
      R_ADJ:   state_nxt = R_CLIP;
      R_CLIP:  state_nxt = R_DONE;
      R_DONE:  state_nxt = R_IDLE;
      default: state_nxt = R_IDLE;
    endcase
  end

  // multiplier operands and handshake
  always_comb begin
    op_a = p_r;
    op_b = p_r;
    unique case (state_r)
      R_SLA: begin
        op_a = prod_r[PER_W-1:0];
        op_b = accel;
      end
      R_SHA: begin
        op_a = shi_r;
        op_b = accel;
      end
      R_QLP: begin
        op_a = q_r[PER_W-1:0];
        op_b = p_r;
      end
      R_QHP: begin
        op_a = q_r[2*PER_W-1:PER_W];
        op_b = p_r;
      end
      default: begin
        op_a = p_r;
        op_b = p_r;
      end
    endcase
    rsp.done   = (state_r == R_DONE);
    rsp.period = np_r;
  end

  assign sum33 = {1'b0, p_r} + {1'b0, d_r[PER_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      R_IDLE: begin
        if (req.start) begin
          p_r   <= req.period;
          brk_r <= req.braking;
        end
      end
      R_SLA:  shi_r <= prod_r[2*PER_W-1:PER_W];
      R_SHA:  hi_r <= prod_r[2*PER_W-1:PER_W];
      R_QSUM: q_r <= prod_r + {{PER_W{1'b0}}, hi_r};
      R_QHP:  hi_r <= prod_r[2*PER_W-1:PER_W];
      R_DSUM: d_r <= prod_r + {{PER_W{1'b0}}, hi_r};
      R_ADJ: begin
        if (brk_r) begin
          if ((|d_r[2*PER_W-1:PER_W]) || sum33[PER_W]) begin
            raw_r <= {PER_W{1'b1}};
          end else begin
            raw_r <= sum33[PER_W-1:0];
          end
        end else begin
          if ((|d_r[2*PER_W-1:PER_W]) || (d_r[PER_W-1:0] >= p_r)) begin
            raw_r <= cruise;
          end else begin
            raw_r <= p_r - d_r[PER_W-1:0];
          end
        end
      end
      R_CLIP: np_r <= (raw_r < cruise) ? cruise : raw_r;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/stepper_trapezoid_ramp_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Ports                         Contents
// in       in   in_tvalid/in_tready           tuser: req_type; tdata: move_value
// out      out  out_tvalid/out_tready         tdata: step_pulse, reverse, position, done_res
// cfg      in   cfg_we/cfg_index/cfg_wdata    register writes, no read-back
//
// A tick that steps also runs the period update: five 32x32 products through one
// registered multiplier plus sum, adjust and clip steps.
// in_tready is high only while idle; a finished result sits in the output register, so
// the next transaction is taken while it waits.
// Reset is synchronous, active low, and loads the register defaults.

module stepper_trapezoid_ramp_generator
  import srg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [VAL_W-1:0]  in_tdata,   // [31:0] move_value
  input  wire logic [KIND_W-1:0] in_tuser,   // [1:0] req_type
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [OUT_W-1:0]  out_tdata,  // [0] step_pulse, [1] reverse,
                                             // [33:2] position, [34] done_res
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [PER_W-1:0]  cfg_wdata
);

  ctl_state_t state_r, state_nxt;

  logic [PER_W-1:0]  start_period_r;
  logic [PER_W-1:0]  cruise_period_r;
  logic [BRK_W-1:0]  full_brake_r;
  logic [PER_W-1:0]  accel_r;

  logic [VAL_W-1:0]  pos_r;
  logic [VAL_W-1:0]  target_r;
  logic              moving_back_r;
  logic [BRK_W-1:0]  brake_r;
  logic [PER_W-1:0]  np_r;
  logic              braking_r;
  logic [PER_W-1:0]  since_r;
  logic [KIND_W-1:0] kind_r;
  logic              pulse_r;
  logic [VAL_W:0]    diff_r;
  logic [VAL_W:0]    dist_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic      in_fire;
  logic      out_free;
  logic      at_target;
  logic      brk_hit;
  ramp_req_t ramp_req;
  ramp_rsp_t ramp_rsp;

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign at_target = (pos_r == target_r);
  assign brk_hit   = (dist_r == {2'b00, brake_r});

  srg_ramp u_ramp (
    .clk    (clk),
    .rst_n  (rst_n),
    .accel  (accel_r),
    .cruise (cruise_period_r),
    .req    (ramp_req),
    .rsp    (ramp_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == REQ_TICK) begin
            state_nxt = S_TICK;
          end else if (in_tuser == REQ_MOVE) begin
            state_nxt = S_DIFF;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_TICK:  state_nxt = at_target ? S_FIN : S_CHECK;
      S_CHECK: state_nxt = (since_r >= {8'd0, np_r[PER_W-1:8]}) ? S_DIFF : S_FIN;
      S_DIFF:  state_nxt = S_ABS;
      S_ABS:   state_nxt = (kind_r == REQ_MOVE) ? S_MSET : S_STEP;
      S_MSET:  state_nxt = S_FIN;
      S_STEP:  state_nxt = S_RAMP;
      S_RAMP:  if (ramp_rsp.done) state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready        = (state_r == S_IDLE);
    ramp_req.start   = (state_r == S_STEP);
    ramp_req.braking = braking_r || brk_hit;
    ramp_req.period  = np_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      start_period_r  <= START_PERIOD_RST;
      cruise_period_r <= CRUISE_PERIOD_RST;
      full_brake_r    <= FULL_BRAKE_RST;
      accel_r         <= ACCEL_RST;
      pos_r           <= '0;
      target_r        <= '0;
      moving_back_r   <= 1'b0;
      brake_r         <= '0;
      np_r            <= '0;
      braking_r       <= 1'b0;
      since_r         <= '0;
      pulse_r         <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_PERIOD:  start_period_r  <= cfg_wdata;
          CFG_CRUISE_PERIOD: cruise_period_r <= cfg_wdata;
          CFG_FULL_BRAKE:    full_brake_r    <= cfg_wdata[BRK_W-1:0];
          CFG_ACCEL:         accel_r         <= cfg_wdata;
          default: ;
        endcase
      end

      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            pulse_r <= 1'b0;
            if (in_tuser == REQ_MOVE) begin
              target_r <= in_tdata;
            end else if (in_tuser == REQ_PRESET) begin
              pos_r <= in_tdata;
            end
          end
        end
        S_TICK: begin
          if (!at_target && (since_r != {PER_W{1'b1}})) begin
            since_r <= since_r + 1'b1;
          end
        end
        S_ABS: begin
          if (kind_r == REQ_MOVE) begin
            moving_back_r <= diff_r[VAL_W];
          end
        end
        S_MSET: begin
          if (dist_r <= {1'b0, full_brake_r, 1'b0}) begin
            brake_r <= dist_r[BRK_W:1];
          end else begin
            brake_r <= full_brake_r;
          end
          np_r      <= start_period_r;
          braking_r <= 1'b0;
          since_r   <= '0;
        end
        S_STEP: begin
          braking_r <= braking_r || brk_hit;
          pos_r     <= moving_back_r ? pos_r - 1'b1 : pos_r + 1'b1;
        end
        S_RAMP: begin
          if (ramp_rsp.done) begin
            np_r    <= ramp_rsp.period;
            since_r <= '0;
            pulse_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_tuser;
    end
    if (state_r == S_DIFF) begin
      diff_r <= {target_r[VAL_W-1], target_r} - {pos_r[VAL_W-1], pos_r};
    end
    if (state_r == S_ABS) begin
      dist_r <= diff_r[VAL_W] ? (~diff_r + 1'b1) : diff_r;
    end
    if ((state_r == S_FIN) && out_free) begin
      out_data_r <= {5'd0, at_target, pos_r, moving_back_r, pulse_r};
    end
  end

endmodule

`default_nettype wire

@@ rtl/srg_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  // after reset: idle and empty
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("not idle after reset");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready held after accept");

  // a result never appears in the cycle after its transaction
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid))
    else $error("result too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind stepper_trapezoid_ramp_generator srg_checker u_srg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import srg_pkg::*;

  localparam logic [KIND_W-1:0] REQ_UNDEF = 2'd3;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_LEN     = 300;
  localparam int IDLE_LIMIT   = 4000;

  typedef struct packed {
    logic        pulse;
    logic        rev;
    logic [31:0] pos;
    logic        at_goal;
  } step_res_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [VAL_W-1:0]  in_tdata;   // [31:0] move_value
  logic [KIND_W-1:0] in_tuser;   // [1:0] req_type
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // [0] step_pulse, [1] reverse, [33:2] position, [34] done_res
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [PER_W-1:0]  cfg_wdata;

  stepper_trapezoid_ramp_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // motor predictor: registers and state
  logic [PER_W-1:0] r_start, r_cruise, r_accel;
  logic [BRK_W-1:0] r_full_brake;
  logic [31:0]      mot_pos, mot_goal, mot_period, mot_ticks;
  logic [BRK_W-1:0] mot_brake_at;
  logic             mot_rev, mot_braking;

  step_res_t pending_res[$];
  step_res_t want;

  int  n_errors, n_items, n_results, n_steps, n_brake_steps, n_moves, n_presets, n_holds;
  int  idle_cycles;
  bit  in_gaps, out_gaps, hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint steps_to_target();
    longint d;
    d = longint'($signed(mot_goal)) - longint'($signed(mot_pos));
    return (d < 0) ? -d : d;
  endfunction

  function automatic logic [31:0] next_step_period(logic [31:0] p, logic brk);
    logic [127:0] prod;
    logic [63:0]  q, d;
    logic [64:0]  s;
    logic [31:0]  np;
    prod = 128'(p) * 128'(p) * 128'(r_accel);
    q    = prod[95:32];
    prod = 128'(q) * 128'(p);
    d    = prod[95:32];
    if (brk) begin
      s  = 65'(p) + 65'(d);
      np = (s > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    end else begin
      np = (d >= 64'(p)) ? r_cruise : p - d[31:0];
    end
    if (np < r_cruise) np = r_cruise;
    return np;
  endfunction

  function automatic void advance_motor(logic [KIND_W-1:0] kind, logic [31:0] val);
    step_res_t r;
    longint    travel;
    r.pulse = 1'b0;
    case (kind)
      REQ_MOVE: begin
        mot_goal     = val;
        mot_rev      = $signed(mot_goal) < $signed(mot_pos);
        travel       = steps_to_target();
        mot_brake_at = r_full_brake;
        if (travel <= 2 * longint'(r_full_brake)) mot_brake_at = BRK_W'(travel / 2);
        mot_period   = r_start;
        mot_braking  = 1'b0;
        mot_ticks    = '0;
        n_moves++;
      end
      REQ_PRESET: begin
        mot_pos = val;
        n_presets++;
      end
      REQ_TICK: begin
        if (mot_pos != mot_goal) begin
          if (mot_ticks != 32'hFFFF_FFFF) mot_ticks++;
          if (mot_ticks >= (mot_period >> 8)) begin
            if (steps_to_target() == longint'(mot_brake_at)) mot_braking = 1'b1;
            mot_pos    = mot_rev ? mot_pos - 32'd1 : mot_pos + 32'd1;
            mot_period = next_step_period(mot_period, mot_braking);
            mot_ticks  = '0;
            r.pulse    = 1'b1;
            n_steps++;
            if (mot_braking) n_brake_steps++;
          end
        end
      end
      default: ;
    endcase
    r.rev     = mot_rev;
    r.pos     = mot_pos;
    r.at_goal = (mot_pos == mot_goal);
    pending_res.push_back(r);
  endfunction

  task automatic send_req(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] val);
    @(negedge clk);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    advance_motor(kind, val);
    n_items++;
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [PER_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_START_PERIOD:  r_start      = val;
      CFG_CRUISE_PERIOD: r_cruise     = val;
      CFG_FULL_BRAKE:    r_full_brake = val[BRK_W-1:0];
      CFG_ACCEL:         r_accel      = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] sp, input logic [31:0] cp,
                           input logic [30:0] fb, input logic [31:0] ac);
    drain();
    write_reg(CFG_START_PERIOD, sp);
    write_reg(CFG_CRUISE_PERIOD, cp);
    write_reg(CFG_FULL_BRAKE, {1'b0, fb});
    write_reg(CFG_ACCEL, ac);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly complete moves with random distance, some presets, retargets and junk
  task automatic run_moves(input int budget, input int max_travel, input int tick_cap);
    int          first, ticks, r, k;
    logic [31:0] tgt;
    first = n_items;
    while (n_items - first < budget) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_req(KIND_W'($urandom_range(0, 3)), $urandom);
      end else if (r < 10) begin
        send_req(REQ_PRESET, $urandom);
      end else begin
        k   = $urandom_range(0, max_travel);
        tgt = ($urandom_range(0, 1) != 0) ? mot_pos + 32'(k) : mot_pos - 32'(k);
        send_req(REQ_MOVE, tgt);
        ticks = 0;
        while (mot_pos != mot_goal && ticks < tick_cap && n_items - first < budget) begin
          r = $urandom_range(0, 199);
          if (r == 0) begin
            send_req(REQ_MOVE, mot_pos + 32'($urandom_range(0, 2 * max_travel))
                                       - 32'(max_travel));
          end else if (r == 1) begin
            send_req(REQ_PRESET, mot_rev ? mot_goal + 32'd1 : mot_goal - 32'd1);
          end else if (r == 2) begin
            send_req(REQ_UNDEF, $urandom);
          end else begin
            send_req(REQ_TICK, $urandom);
            ticks++;
          end
        end
        repeat ($urandom_range(0, 2)) send_req(REQ_TICK, $urandom);
      end
    end
  endtask

  task automatic test_directed();
    send_req(REQ_TICK, 32'h0);
    send_req(REQ_UNDEF, 32'hFFFF_FFFF);
    send_req(REQ_PRESET, 32'h7FFF_FFFF);
    send_req(REQ_PRESET, 32'h8000_0000);
    send_req(REQ_MOVE, 32'h8000_0000);
    send_req(REQ_TICK, 32'hFFFF_FFFF);
    send_req(REQ_PRESET, 32'h0);
    send_req(REQ_MOVE, 32'd3);
    send_req(REQ_TICK, 32'h0);
    send_req(REQ_TICK, 32'h0);
    // sub-microsecond period: a step on every tick
    load_regs(32'h80, 32'd1, 31'd1, 32'hFFFF_FFFF);
    send_req(REQ_PRESET, 32'h7FFF_FFFE);
    send_req(REQ_MOVE, 32'h8000_0001);
    send_req(REQ_TICK, 32'h0);
    send_req(REQ_TICK, 32'h0);
    // preset mid-move, position wraps going down
    send_req(REQ_PRESET, 32'h8000_0000);
    send_req(REQ_TICK, 32'h0);
    send_req(REQ_TICK, 32'h0);
    send_req(REQ_PRESET, 32'h8000_0003);
    repeat (3) send_req(REQ_TICK, 32'h0);
    send_req(REQ_TICK, 32'h5555_AAAA);
    send_req(REQ_UNDEF, 32'h0);
    send_req(REQ_MOVE, 32'h8000_0006);
    repeat (5) send_req(REQ_TICK, 32'hAAAA_5555);
  endtask

  task automatic test_fast_steps();
    load_regs($urandom_range(1, 255), $urandom_range(1, 64), 31'($urandom_range(0, 6)),
              $urandom);
    hold_req = 1'b1;
    run_moves(300, 12, 60);
  endtask

  task automatic test_accel_ramp();
    load_regs($urandom_range(8192, 40000), $urandom_range(2560, 6000),
              31'($urandom_range(1, 3)), $urandom_range(32'h8000_0000, 32'hFFFF_FFFF));
    run_moves(400, 6, 1500);
  endtask

  task automatic test_register_extremes();
    load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0);
    run_moves(40, 1000, 8);
  endtask

  task automatic test_unit_period();
    load_regs(32'd1, 32'd1, 31'd0, 32'h0);
    run_moves(250, 20, 60);
  endtask

  task automatic test_cruise_clip();
    load_regs($urandom_range(60000, 80000), $urandom_range(12000, 20000),
              31'($urandom_range(1, 2)), 32'hFFFF_FFFF);
    run_moves(450, 3, 1500);
  endtask

  task automatic test_back_to_back();
    load_regs($urandom_range(1, 255), $urandom_range(1, 255), 31'($urandom_range(0, 6)),
              $urandom);
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    run_moves(200, 12, 60);
  endtask

  task automatic finish_run();
    drain();
    $display("covered %0d transactions: %0d moves, %0d presets, %0d steps (%0d braking)",
             n_items, n_moves, n_presets, n_steps, n_brake_steps);
    $display("%0d results checked, %0d long output holds, %0d errors",
             n_results, n_holds, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = REQ_TICK;
    cfg_we       = 1'b0;
    cfg_index    = CFG_START_PERIOD;
    cfg_wdata    = '0;
    in_gaps      = 1'b1;
    out_gaps     = 1'b1;
    hold_req     = 1'b0;
    r_start      = START_PERIOD_RST;
    r_cruise     = CRUISE_PERIOD_RST;
    r_full_brake = FULL_BRAKE_RST;
    r_accel      = ACCEL_RST;
    mot_pos      = '0;
    mot_goal     = '0;
    mot_rev      = 1'b0;
    mot_brake_at = '0;
    mot_period   = '0;
    mot_braking  = 1'b0;
    mot_ticks    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fast_steps();
    test_accel_ramp();
    test_register_extremes();
    test_unit_period();
    test_cruise_clip();
    test_back_to_back();
    finish_run();
  end

  // result sink: random back-pressure plus one long hold
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        n_holds++;
      end else if (out_gaps && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_res.size() == 0) begin
        $error("result with no transaction pending: %h", out_tdata);
        n_errors++;
      end else begin
        want = pending_res.pop_front();
        if (out_tdata[0] !== want.pulse) begin
          $error("step_pulse: expected %0d, got %0d", want.pulse, out_tdata[0]);
          n_errors++;
        end
        if (out_tdata[1] !== want.rev) begin
          $error("reverse: expected %0d, got %0d", want.rev, out_tdata[1]);
          n_errors++;
        end
        if (out_tdata[33:2] !== want.pos) begin
          $error("position: expected %0d, got %0d", $signed(want.pos),
                 $signed(out_tdata[33:2]));
          n_errors++;
        end
        if (out_tdata[34] !== want.at_goal) begin
          $error("done_res: expected %0d, got %0d", want.at_goal, out_tdata[34]);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
